### design/agfs_pkg.sv
// shared types, character codes and defaults for the +CGPSINFO field splitter
package agfs_pkg;

    // default sizing handed to the top level
    localparam int DEF_MAX_LINE   = 256;
    localparam int DEF_NUM_FIELDS = 9;

    // fixed field widths
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 4;
    localparam int POS_W   = 8;
    localparam int PM_W    = 4;

    // prefix text length
    localparam logic [PM_W-1:0] PREFIX_LEN = PM_W'(10);

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;

    // result status codes
    localparam logic STATUS_FIELD     = 1'b0;
    localparam logic STATUS_NO_PREFIX = 1'b1;

    // parser phase
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_SKIP   = 2'd1,
        PH_FIELD  = 2'd2,
        PH_TAIL   = 2'd3
    } t_phase;

    // one result
    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] index;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   length;
        logic               last;
    } t_result;

    // request to emit the remaining empty fields after an early terminator
    typedef struct packed {
        logic               start;
        logic [INDEX_W-1:0] index;
    } t_flush;

    // expected byte of "+CGPSINFO:" at a given match count
    function automatic logic [CHAR_W-1:0] prefix_char(input logic [PM_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0: c = 8'h2b;    // +
            4'd1: c = 8'h43;    // C
            4'd2: c = 8'h47;    // G
            4'd3: c = 8'h50;    // P
            4'd4: c = 8'h53;    // S
            4'd5: c = 8'h49;    // I
            4'd6: c = 8'h4e;    // N
            4'd7: c = 8'h46;    // F
            4'd8: c = 8'h4f;    // O
            4'd9: c = 8'h3a;    // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### design/at_gps_info_field_splitter.sv
// top level of the +CGPSINFO comma field splitter with input and result registers
//
//  channel | dir | signals                      | contents
//  --------+-----+------------------------------+-----------------------------------
//  s       | in  | i_s_tvalid/o_s_tready/tdata  | one response byte, 0 ends string
//  m       | out | o_m_tvalid/i_m_tready/tdata  | index, start, length; tuser status;
//          |     | tuser/tlast                  | tlast on final result of a string
//
// one byte per cycle unless stalled; each byte passes the input register, then the parser into the result register
// a terminator inside the fields holds the input while the remaining empty fields are emitted
// i_rst_n is synchronous, active low; parser state returns to prefix search
// on a stalled output, bytes with no result still pass; the first with one waits at the input
module at_gps_info_field_splitter #(
    parameter int MAX_LINE   = agfs_pkg::DEF_MAX_LINE,
    parameter int NUM_FIELDS = agfs_pkg::DEF_NUM_FIELDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] char_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,     // [3:0] field_index, [11:4] field_start,
                                       // [19:12] field_length, [23:20] zero
    output logic        o_m_tuser,     // [0] status
    output logic        o_m_tlast      // last
);
    import agfs_pkg::*;

    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(NUM_FIELDS - 1);

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_result            r_out;
    logic               r_flush_active;
    logic [INDEX_W-1:0] r_flush_idx;

    logic               res_valid;
    t_result            res;
    t_flush             flush;
    logic               out_free, consume, flush_emit, flush_done;

    // parser
    agfs_parser #(
        .MAX_LINE   (MAX_LINE),
        .NUM_FIELDS (NUM_FIELDS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (consume),
        .i_char      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_flush     (flush)
    );

    // handshake control
    assign out_free   = !r_out_valid || i_m_tready;
    assign consume    = r_in_valid && !r_flush_active && (!res_valid || out_free);
    assign flush_emit = r_flush_active && out_free;
    assign flush_done = (r_flush_idx == LAST_IDX);
    assign o_s_tready = !r_in_valid || consume;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // empty-field flush after an early terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_active <= 1'b0;
            r_flush_idx    <= '0;
        end else if (consume && flush.start) begin
            r_flush_active <= 1'b1;
            r_flush_idx    <= flush.index;
        end else if (flush_emit) begin
            r_flush_active <= !flush_done;
            r_flush_idx    <= r_flush_idx + INDEX_W'(1);
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((consume && res_valid) || flush_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (consume && res_valid) begin
            r_out <= res;
        end else if (flush_emit) begin
            r_out.status <= STATUS_FIELD;
            r_out.index  <= r_flush_idx;
            r_out.start  <= '0;
            r_out.length <= '0;
            r_out.last   <= flush_done;
        end
    end

    // output packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'h0, r_out.length, r_out.start, r_out.index};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

    // a flush never runs past the final field
    a_flush_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_active |-> ({1'b0, r_flush_idx} <= {1'b0, LAST_IDX}))
        else $error("flush index beyond final field");

    // a prefix error is a single empty result closing the string
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STATUS_NO_PREFIX) |->
            (r_out.last && r_out.index == '0 && r_out.length == '0))
        else $error("malformed prefix error result");

    // a field report closes the string exactly at the final field
    a_field_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STATUS_FIELD) |->
            (r_out.last == (r_out.index == LAST_IDX)))
        else $error("last flag does not match final field");

    // finishing the flush stops it on the next cycle
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (flush_emit && flush_done) |=> !r_flush_active)
        else $error("flush continued after final field");

endmodule

### design/agfs_parser.sv
// per-byte parser: prefix search, space skip, field split and position state
module agfs_parser #(
    parameter int MAX_LINE   = agfs_pkg::DEF_MAX_LINE,
    parameter int NUM_FIELDS = agfs_pkg::DEF_NUM_FIELDS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_char,
    output logic                   o_res_valid,
    output agfs_pkg::t_result      o_res,
    output agfs_pkg::t_flush       o_flush
);
    import agfs_pkg::*;

    localparam int POS_CAP_I = (MAX_LINE - 1) < 255 ? (MAX_LINE - 1) : 255;
    localparam logic [POS_W-1:0] POS_CAP  = POS_W'(POS_CAP_I);
    localparam logic [INDEX_W:0] LAST_IDX = (INDEX_W + 1)'(NUM_FIELDS - 1);

    t_phase             r_phase, n_phase;
    logic [PM_W-1:0]    r_pm, n_pm;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [INDEX_W-1:0] r_cf, n_cf;
    logic [POS_W-1:0]   r_fb, n_fb;

    logic               is_nul, is_comma, is_space, pre_hit;
    logic               enter_field, in_field, cf_last, pos_open;
    logic [POS_W-1:0]   e_fb, len;
    logic [INDEX_W-1:0] e_cf;

    // byte classification and effective field context
    assign is_nul      = (i_char == CHAR_NUL);
    assign is_comma    = (i_char == CHAR_COMMA);
    assign is_space    = (i_char == CHAR_SPACE);
    assign pre_hit     = (r_pm < PREFIX_LEN) && (i_char == prefix_char(r_pm));
    assign enter_field = (r_phase == PH_SKIP) && !is_space;
    assign in_field    = (r_phase == PH_FIELD) || enter_field;
    assign e_fb        = enter_field ? r_pos : r_fb;
    assign e_cf        = enter_field ? '0 : r_cf;
    assign cf_last     = ({1'b0, e_cf} == LAST_IDX);
    assign len         = r_pos - e_fb;
    assign pos_open    = (r_pos < POS_CAP);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_SEARCH: begin
                if (!is_nul && pre_hit && (r_pm == PREFIX_LEN - PM_W'(1))) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP, PH_FIELD: begin
                if (in_field) begin
                    if (is_nul) begin
                        n_phase = PH_SEARCH;
                    end else if (is_comma && cf_last) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase = PH_FIELD;
                    end
                end
            end
            PH_TAIL: begin
                if (is_nul) begin
                    n_phase = PH_SEARCH;
                end
            end
            default: n_phase = PH_SEARCH;
        endcase
    end

    // next counters and offsets
    always_comb begin
        n_pm  = r_pm;
        n_pos = pos_open ? r_pos + POS_W'(1) : r_pos;
        n_cf  = r_cf;
        n_fb  = r_fb;
        if (is_nul) begin
            n_pm  = '0;
            n_pos = '0;
            n_cf  = '0;
            n_fb  = '0;
        end else if (r_phase == PH_SEARCH) begin
            if (pre_hit) begin
                n_pm = r_pm + PM_W'(1);
            end else begin
                n_pm = (i_char == CHAR_PLUS) ? PM_W'(1) : '0;
            end
        end else if (in_field) begin
            n_cf = e_cf;
            n_fb = e_fb;
            if (is_comma && !cf_last) begin
                n_cf = e_cf + INDEX_W'(1);
                n_fb = pos_open ? r_pos + POS_W'(1) : POS_CAP;
            end
        end
    end

    // result and flush request
    always_comb begin
        o_res_valid   = 1'b0;
        o_res.status  = STATUS_FIELD;
        o_res.index   = e_cf;
        o_res.start   = (len == '0) ? '0 : e_fb;
        o_res.length  = len;
        o_res.last    = cf_last;
        o_flush.start = 1'b0;
        o_flush.index = e_cf + INDEX_W'(1);
        if (r_phase == PH_SEARCH) begin
            o_res_valid  = is_nul;
            o_res.status = STATUS_NO_PREFIX;
            o_res.index  = '0;
            o_res.start  = '0;
            o_res.length = '0;
            o_res.last   = 1'b1;
        end else if (in_field) begin
            o_res_valid   = is_nul || is_comma;
            o_flush.start = is_nul && !cf_last;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_pm    <= '0;
            r_pos   <= '0;
            r_cf    <= '0;
            r_fb    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pm    <= n_pm;
            r_pos   <= n_pos;
            r_cf    <= n_cf;
            r_fb    <= n_fb;
        end
    end

endmodule
